[rtl/cior_pkg.sv]
// ----------------------------------------------------------------------------
// CPU I/O register block package
// Shared command codes, register offsets, controller states and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package cior_pkg;

  // Item commands.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_NMI   = 2'd2;
  localparam logic [1:0] CMD_IRQ   = 2'd3;

  // Register offsets.
  localparam logic [4:0] OFF_NMITIMEN = 5'h00;
  localparam logic [4:0] OFF_WRIO     = 5'h01;
  localparam logic [4:0] OFF_WRMPYA   = 5'h02;
  localparam logic [4:0] OFF_WRMPYB   = 5'h03;
  localparam logic [4:0] OFF_WRDIVL   = 5'h04;
  localparam logic [4:0] OFF_WRDIVH   = 5'h05;
  localparam logic [4:0] OFF_WRDIVB   = 5'h06;
  localparam logic [4:0] OFF_HTIMEL   = 5'h07;
  localparam logic [4:0] OFF_HTIMEH   = 5'h08;
  localparam logic [4:0] OFF_VTIMEL   = 5'h09;
  localparam logic [4:0] OFF_VTIMEH   = 5'h0a;
  localparam logic [4:0] OFF_RDNMI    = 5'h10;
  localparam logic [4:0] OFF_TIMEUP   = 5'h11;
  localparam logic [4:0] OFF_HVBJOY   = 5'h12;
  localparam logic [4:0] OFF_RDIO     = 5'h13;
  localparam logic [4:0] OFF_RDDIVL   = 5'h14;
  localparam logic [4:0] OFF_RDDIVH   = 5'h15;
  localparam logic [4:0] OFF_RDMPYL   = 5'h16;
  localparam logic [4:0] OFF_RDMPYH   = 5'h17;
  localparam logic [4:0] OFF_JOY1L    = 5'h18;
  localparam logic [4:0] OFF_JOY1H    = 5'h19;
  localparam logic [4:0] OFF_JOY2L    = 5'h1a;
  localparam logic [4:0] OFF_JOY2H    = 5'h1b;

  // Beam constants.
  localparam int unsigned HBLANK_START   = 1024;
  localparam int unsigned VBLANK_START   = 225;
  localparam int unsigned VBLANK_START_OS = 240;
  localparam int unsigned STATUS_STEP    = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // capture item and perform the non-iterative work
    logic div_step;  // one restoring-division step
    logic finish;    // write quotient and remainder
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_start; // accepted item starts a division
    logic div_last;  // current step is the last one
  } dp_status_t;

  function automatic logic [15:0] reverse16(input logic [15:0] w);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = w[15-i];
    return r;
  endfunction

endpackage

[rtl/cior_ctrl.sv]
// ----------------------------------------------------------------------------
// CPU I/O register block controller
// Sequences acceptance, the sixteen division steps and the result word.
// ----------------------------------------------------------------------------
module cior_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  cior_pkg::dp_status_t status_i,
  output cior_pkg::dp_cmd_t    cmd_o
);
  import cior_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid) state_d = status_i.div_start ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall        = (state_q != ST_IDLE);
    out_valid       = (state_q == ST_DONE);
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid;
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.finish    = (state_q == ST_DIV) && status_i.div_last;
  end

endmodule

[rtl/cior_dp.sv]
// ----------------------------------------------------------------------------
// CPU I/O register block datapath
// Registers, beam counter, multiplier, iterative divider and result word.
// ----------------------------------------------------------------------------
module cior_dp #(
  parameter int unsigned LINE_CYCLES = 1364,
  parameter int unsigned FRAME_LINES = 262
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 overscan_i,
  input  cior_pkg::dp_cmd_t     cmd_i,
  output cior_pkg::dp_status_t  status_o,
  input  logic [1:0]           command_i,
  input  logic [4:0]           reg_offset_i,
  input  logic [7:0]           write_data_i,
  input  logic [15:0]          pad1_state_i,
  input  logic [15:0]          pad2_state_i,
  output logic [7:0]           read_data_o,
  output logic                 counter_latched_o,
  output logic [8:0]           latched_h_o,
  output logic [8:0]           latched_v_o,
  output logic                 nmi_enable_o,
  output logic                 h_irq_enable_o,
  output logic                 v_irq_enable_o,
  output logic                 auto_joy_enable_o,
  output logic [8:0]           h_timer_value_o,
  output logic [8:0]           v_timer_value_o
);
  import cior_pkg::*;

  logic [10:0] beam_h_q;
  logic [8:0]  beam_v_q;
  logic        vblank_q, nmi_flag_q, irq_flag_q, latch_q;
  logic [3:0]  en_q;
  logic [7:0]  mul_a_q;
  logic [15:0] prod_q, divd_q, quot_q;
  logic [8:0]  htime_q, vtime_q;
  logic [7:0]  rd_q;
  logic        lat_q;
  logic [8:0]  lh_q, lv_q;
  // Divider working registers.
  logic [15:0] dq_q;
  logic [7:0]  dr_q;
  logic [7:0]  rem_q;
  logic [3:0]  cnt_q;

  // Beam advance for a status read (by STATUS_STEP) or latch (one whole line).
  logic        is_rd, is_wr, status_rd, latch_fall;
  logic [11:0] h_sum;
  logic [10:0] h_next;
  logic        h_wrap;
  logic [8:0]  v_inc, v_next;
  logic        vb_next;

  assign is_rd      = command_i == CMD_READ;
  assign is_wr      = command_i == CMD_WRITE;
  assign status_rd  = is_rd && reg_offset_i == OFF_HVBJOY;
  assign latch_fall = is_wr && reg_offset_i == OFF_WRIO && !write_data_i[7] && latch_q;

  always_comb begin
    if (latch_fall) begin
      h_next = beam_h_q;
      h_wrap = 1'b1;
      h_sum  = 12'(beam_h_q);
    end else begin
      h_sum  = 12'(beam_h_q) + 12'(STATUS_STEP);
      h_wrap = h_sum >= 12'(LINE_CYCLES);
      h_next = h_wrap ? 11'(h_sum - 12'(LINE_CYCLES)) : h_sum[10:0];
    end
    v_inc   = beam_v_q + 9'(h_wrap);
    v_next  = (10'(beam_v_q) + 10'(h_wrap) >= 10'(FRAME_LINES)) ? 9'd0 : v_inc;
    vb_next = v_next >= (overscan_i ? 9'(VBLANK_START_OS) : 9'(VBLANK_START));
  end

  // Division step: restoring, one quotient bit per cycle.
  logic [8:0]  trial;
  logic        fits;
  assign trial = {rem_q, dq_q[15]};
  assign fits  = trial >= {1'b0, dr_q};
  assign status_o.div_start = is_wr && reg_offset_i == OFF_WRDIVB && write_data_i != 8'd0;
  assign status_o.div_last  = cnt_q == 4'd15;

  logic [15:0] rev1, rev2;
  assign rev1 = reverse16(pad1_state_i);
  assign rev2 = reverse16(pad2_state_i);

  // Control and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_h_q   <= '0;
      beam_v_q   <= '0;
      vblank_q   <= 1'b0;
      nmi_flag_q <= 1'b0;
      irq_flag_q <= 1'b0;
      en_q       <= '0;
      latch_q    <= 1'b0;
      mul_a_q    <= 8'hff;
      prod_q     <= 16'hfe01;
      divd_q     <= 16'hffff;
      quot_q     <= 16'h0101;
      htime_q    <= 9'h1ff;
      vtime_q    <= 9'h1ff;
    end else if (cmd_i.accept) begin
      if (status_rd || latch_fall) begin
        beam_h_q <= h_next;
        beam_v_q <= v_next;
        vblank_q <= vb_next;
      end
      unique case (command_i)
        CMD_NMI: nmi_flag_q <= 1'b1;
        CMD_IRQ: irq_flag_q <= 1'b1;
        CMD_READ: begin
          if (reg_offset_i == OFF_RDNMI)  nmi_flag_q <= 1'b0;
          if (reg_offset_i == OFF_TIMEUP) irq_flag_q <= 1'b0;
        end
        default: begin
          priority case (reg_offset_i)
            OFF_NMITIMEN: begin
              en_q <= {write_data_i[7], write_data_i[5], write_data_i[4], write_data_i[0]};
              if (!write_data_i[5] && !write_data_i[4]) irq_flag_q <= 1'b0;
            end
            OFF_WRIO:   latch_q <= write_data_i[7];
            OFF_WRMPYA: mul_a_q <= write_data_i;
            OFF_WRMPYB: prod_q  <= 16'(mul_a_q) * 16'(write_data_i);
            OFF_WRDIVL: divd_q[7:0]  <= write_data_i;
            OFF_WRDIVH: divd_q[15:8] <= write_data_i;
            OFF_WRDIVB: begin
              if (write_data_i == 8'd0) begin
                quot_q <= 16'hffff;
                prod_q <= divd_q;
              end
            end
            OFF_HTIMEL: htime_q[7:0] <= write_data_i;
            OFF_HTIMEH: htime_q[8]   <= write_data_i[0];
            OFF_VTIMEL: vtime_q[7:0] <= write_data_i;
            OFF_VTIMEH: vtime_q[8]   <= write_data_i[0];
            default: ;
          endcase
        end
      endcase
    end else if (cmd_i.finish) begin
      quot_q <= {dq_q[14:0], fits};
      prod_q <= {8'd0, fits ? 8'(trial - {1'b0, dr_q}) : trial[7:0]};
    end
  end

  // Divider iteration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      cnt_q <= '0;
      dq_q  <= divd_q;
      dr_q  <= write_data_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 4'd1;
      dq_q  <= {dq_q[14:0], fits};
      rem_q <= fits ? 8'(trial - {1'b0, dr_q}) : trial[7:0];
    end
  end

  // Result word, captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lat_q <= latch_fall;
      lh_q  <= latch_fall ? 9'(h_next >> 2) : 9'd0;
      lv_q  <= latch_fall ? v_next : 9'd0;
      if (is_rd) begin
        priority case (reg_offset_i)
          OFF_RDNMI:  rd_q <= {nmi_flag_q, 7'h02};
          OFF_TIMEUP: rd_q <= {irq_flag_q, 7'h00};
          OFF_HVBJOY: rd_q <= {vb_next, h_next >= 11'(HBLANK_START), 6'h00};
          OFF_RDIO:   rd_q <= {latch_q, 7'h00};
          OFF_RDDIVL: rd_q <= quot_q[7:0];
          OFF_RDDIVH: rd_q <= quot_q[15:8];
          OFF_RDMPYL: rd_q <= prod_q[7:0];
          OFF_RDMPYH: rd_q <= prod_q[15:8];
          OFF_JOY1L:  rd_q <= rev1[7:0];
          OFF_JOY1H:  rd_q <= rev1[15:8];
          OFF_JOY2L:  rd_q <= rev2[7:0];
          OFF_JOY2H:  rd_q <= rev2[15:8];
          default:    rd_q <= 8'd0;
        endcase
      end else begin
        rd_q <= 8'd0;
      end
    end
  end

  assign read_data_o       = rd_q;
  assign counter_latched_o = lat_q;
  assign latched_h_o       = lh_q;
  assign latched_v_o       = lv_q;
  assign nmi_enable_o      = en_q[3];
  assign v_irq_enable_o    = en_q[2];
  assign h_irq_enable_o    = en_q[1];
  assign auto_joy_enable_o = en_q[0];
  assign h_timer_value_o   = htime_q;
  assign v_timer_value_o   = vtime_q;

endmodule

[rtl/cpu_io_math_irq_registers.sv]
// ----------------------------------------------------------------------------
// CPU I/O math and interrupt registers
// Top level: controller plus datapath, with the overscan register.
// ----------------------------------------------------------------------------
// Each input word is a register read, a register write or an NMI/IRQ flag
// event; each produces exactly one result word. The input channel is
// in_valid/in_stall, the result channel out_valid/out_stall. The result word
// is offered in the cycle after acceptance, or after the division steps for
// a divide by a nonzero divisor: the 16/8 divider resolves one quotient bit
// per cycle. One word is in flight at a time, so a new word is accepted only
// after the result of the last one has been taken. If the receiver stalls,
// the result holds and input stays stalled. Reset clears the beam, flags and
// enables, and loads the multiplier and divider registers and both timer
// compares with their power-up values. The overscan register is written
// through cfg_we/cfg_wdata; the user must write it only while idle, which
// the block does not enforce. It takes effect at the next beam movement.
// ----------------------------------------------------------------------------
module cpu_io_math_irq_registers #(
  parameter int unsigned LINE_CYCLES = 1364,
  parameter int unsigned FRAME_LINES = 262
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command_i,
  input  logic [4:0]  reg_offset_i,
  input  logic [7:0]  write_data_i,
  input  logic [15:0] pad1_state_i,
  input  logic [15:0] pad2_state_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data_o,
  output logic        counter_latched_o,
  output logic [8:0]  latched_h_o,
  output logic [8:0]  latched_v_o,
  output logic        nmi_enable_o,
  output logic        h_irq_enable_o,
  output logic        v_irq_enable_o,
  output logic        auto_joy_enable_o,
  output logic [8:0]  h_timer_value_o,
  output logic [8:0]  v_timer_value_o
);
  import cior_pkg::*;

  logic       overscan_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Overscan register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overscan_q <= 1'b0;
    end else if (cfg_we) begin
      overscan_q <= cfg_wdata;
    end
  end

  cior_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .status_i(status), .cmd_o(cmd)
  );

  cior_dp #(.LINE_CYCLES(LINE_CYCLES), .FRAME_LINES(FRAME_LINES)) u_dp (
    .clk_i, .rst_ni, .overscan_i(overscan_q), .cmd_i(cmd), .status_o(status),
    .command_i, .reg_offset_i, .write_data_i, .pad1_state_i, .pad2_state_i,
    .read_data_o, .counter_latched_o, .latched_h_o, .latched_v_o,
    .nmi_enable_o, .h_irq_enable_o, .v_irq_enable_o, .auto_joy_enable_o,
    .h_timer_value_o, .v_timer_value_o
  );

endmodule
